// ----- hw/rtl/tristate_remote_code_encoder_unit_assert.svh -----
// Assertion macros shared by the tri-state code encoder RTL.
// Each macro expands to one labeled concurrent assertion on the given clock and reset.
`ifndef TRISTATE_REMOTE_CODE_ENCODER_UNIT_ASSERT_SVH
`define TRISTATE_REMOTE_CODE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRCE_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("trce: implication check failed");

// Next-cycle implication, checked outside reset.
`define TRCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("trce: next-cycle check failed");

// A condition that must never hold outside reset.
`define TRCE_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("trce: forbidden condition seen");

`endif

// ----- hw/rtl/trce_pkg.sv -----
// Types, constants and helper functions of the tri-state code encoder.
// Used by the front decoder, the command queue, the segment sequencer and the top level.
package trce_pkg;

  localparam int WordSymbols = 12;
  localparam int SymIdxW     = $clog2(WordSymbols);
  localparam int SegsPerSym  = 4;
  localparam int SegIdxW     = $clog2(SegsPerSym);
  localparam int CmdDepth    = 2;
  localparam int CmdPtrW     = $clog2(CmdDepth);
  localparam int CmdCntW     = $clog2(CmdDepth + 1);

  localparam logic [1:0] CodeBad   = 2'd3;
  localparam logic [5:0] DurShort  = 6'd1;
  localparam logic [5:0] DurLong   = 6'd3;
  localparam logic [5:0] DurSync   = 6'd32;
  localparam logic [5:0] DurNone   = 6'd0;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_X    = 2'd2
  } sym_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYMBOL,
    ST_SYNC_HIGH,
    ST_SYNC_LOW,
    ST_ERROR
  } back_state_e;

  typedef struct packed {
    logic [1:0] house_code;
    logic [1:0] unit_code;
    logic       switch_on;
  } req_t;

  typedef struct packed {
    logic       level;
    logic [5:0] duration_units;
    logic       last;
    logic       bad_code;
  } seg_t;

  // Decoded request: error flag and the code word, symbol 0 sent first.
  typedef struct packed {
    logic                        bad;
    logic [WordSymbols-1:0][1:0] word;
  } cmd_t;

  // Status of the command queue as seen by the sequencer.
  typedef struct packed {
    logic valid;
  } cmd_ctrl_t;

  // Symbol at position idx of the four-symbol group selected by a code of 0, 1 or 2.
  function automatic sym_e group_sym(logic [1:0] code, logic [1:0] idx);
    sym_e s;
    s = SYM_ZERO;
    if (code == 2'd1 && idx == 2'd0) s = SYM_X;
    if (code == 2'd2 && idx == 2'd1) s = SYM_X;
    return s;
  endfunction

  // Length of segment seg (high, low, high, low) of a symbol.
  function automatic logic [5:0] seg_duration(sym_e s, logic [SegIdxW-1:0] seg);
    logic [5:0] d;
    unique case (s)
      SYM_ONE: d = seg[0] ? DurShort : DurLong;
      SYM_X:   d = (seg == SegIdxW'(1) || seg == SegIdxW'(2)) ? DurLong : DurShort;
      default: d = seg[0] ? DurLong : DurShort;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/trce_front.sv -----
// Front decoder: classifies a send request and builds its tri-state code word.
// Depends on trce_pkg; feeds trce_cmd_fifo.
module trce_front import trce_pkg::*; (
  input  logic push_i,
  input  logic full_i,
  input  req_t req_i,
  output cmd_t cmd_o,
  output logic cmd_push_o
);

  always_comb begin
    cmd_o.bad = (req_i.house_code == CodeBad) || (req_i.unit_code == CodeBad);
    for (int i = 0; i < 4; i++) begin
      cmd_o.word[i]     = group_sym(req_i.house_code, 2'(i));
      cmd_o.word[4 + i] = group_sym(req_i.unit_code, 2'(i));
    end
    cmd_o.word[8]  = SYM_ZERO;
    cmd_o.word[9]  = SYM_X;
    cmd_o.word[10] = SYM_X;
    cmd_o.word[11] = req_i.switch_on ? SYM_X : SYM_ZERO;
  end

  assign cmd_push_o = push_i && !full_i;

endmodule

// ----- hw/rtl/trce_cmd_fifo.sv -----
// Short command queue between the front decoder and the segment sequencer.
// Depends on trce_pkg and the assertion macro header.
`include "tristate_remote_code_encoder_unit_assert.svh"

module trce_cmd_fifo import trce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  output cmd_ctrl_t ctrl_o,
  input  logic      pop_i,
  output cmd_t      cmd_o
);

  cmd_t                mem_q [CmdDepth];
  logic [CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == CmdCntW'(CmdDepth));
  assign ctrl_o.valid = (cnt_q != '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `TRCE_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CmdCntW'(CmdDepth))
  `TRCE_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full_o || pop_i)
  `TRCE_ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, ctrl_o.valid)

endmodule

// ----- hw/rtl/trce_back.sv -----
// Segment sequencer: walks a queued code word and emits its pulse segments.
// Depends on trce_pkg and the assertion macro header; the output register sits here.
`include "tristate_remote_code_encoder_unit_assert.svh"

module trce_back import trce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_ctrl_t ctrl_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output seg_t      seg_o
);

  back_state_e         state_q, state_d;
  cmd_t                cmd_q;
  logic [SymIdxW-1:0]  sym_q;
  logic [SegIdxW-1:0]  seg_q;
  logic                out_valid_q;
  seg_t                out_seg_q;

  logic        adv;
  logic        last_seg;
  logic        fetch;
  logic        emit_valid;
  seg_t        emit_seg;
  back_state_e first_state;
  sym_e        cur_sym;

  // The output slot is free when empty or when its segment is taken this cycle.
  assign adv         = !out_valid_q || pop_i;
  assign last_seg    = (state_q == ST_SYNC_LOW) || (state_q == ST_ERROR);
  assign fetch       = ctrl_i.valid && ((state_q == ST_IDLE) || (adv && last_seg));
  assign cmd_pop_o   = fetch;
  assign first_state = cmd_i.bad ? ST_ERROR : ST_SYMBOL;
  assign cur_sym     = sym_e'(cmd_q.word[sym_q]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fetch) state_d = first_state;
      end
      ST_SYMBOL: begin
        if (adv && seg_q == SegIdxW'(SegsPerSym - 1) && sym_q == SymIdxW'(WordSymbols - 1)) begin
          state_d = ST_SYNC_HIGH;
        end
      end
      ST_SYNC_HIGH: begin
        if (adv) state_d = ST_SYNC_LOW;
      end
      ST_SYNC_LOW, ST_ERROR: begin
        if (adv) state_d = fetch ? first_state : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_valid              = 1'b1;
    emit_seg.level          = 1'b0;
    emit_seg.duration_units = DurNone;
    emit_seg.last           = 1'b0;
    emit_seg.bad_code       = 1'b0;
    unique case (state_q)
      ST_SYMBOL: begin
        emit_seg.level          = !seg_q[0];
        emit_seg.duration_units = seg_duration(cur_sym, seg_q);
      end
      ST_SYNC_HIGH: begin
        emit_seg.level          = 1'b1;
        emit_seg.duration_units = DurShort;
      end
      ST_SYNC_LOW: begin
        emit_seg.duration_units = DurSync;
        emit_seg.last           = 1'b1;
      end
      ST_ERROR: begin
        emit_seg.last     = 1'b1;
        emit_seg.bad_code = 1'b1;
      end
      default: emit_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_q       <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fetch) begin
        sym_q <= '0;
        seg_q <= '0;
      end else if (state_q == ST_SYMBOL && adv) begin
        seg_q <= seg_q + 1'b1;
        if (seg_q == SegIdxW'(SegsPerSym - 1)) begin
          sym_q <= sym_q + 1'b1;
        end
      end
      if (adv) begin
        out_valid_q <= emit_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      cmd_q <= cmd_i;
    end
    if (adv && emit_valid) begin
      out_seg_q <= emit_seg;
    end
  end

  assign empty_o = !out_valid_q;
  assign seg_o   = out_seg_q;

  `TRCE_ASSERT_IMPLIES(a_sym_range, clk_i, rst_ni, state_q == ST_SYMBOL,
                       sym_q <= SymIdxW'(WordSymbols - 1))
  `TRCE_ASSERT_IMPLIES(a_fetch_valid, clk_i, rst_ni, cmd_pop_o, ctrl_i.valid)
  `TRCE_ASSERT_IMPLIES(a_error_shape, clk_i, rst_ni, out_valid_q && seg_o.bad_code,
                       seg_o.last && seg_o.duration_units == DurNone && !seg_o.level)
  `TRCE_ASSERT_NEXT(a_sync_follows, clk_i, rst_ni, state_q == ST_SYNC_HIGH && adv,
                    state_q == ST_SYNC_LOW)

endmodule

// ----- hw/rtl/tristate_remote_code_encoder_unit.sv -----
// Tri-state remote code encoder, top level.
// Channels: send requests enter through push/full with req_i (house, unit, on/off).
// Pulse segments leave through empty/pop with res_o (level, duration, last, bad_code);
// the oldest segment is on res_o while empty is low and is taken when pop is high.
// A valid request yields 50 segments: 12 code symbols of four segments each, then
// the sync pair high 1 and low 32, the low one marked last. A request with an
// unsupported house or unit code yields one segment with bad_code and last set.
// A transferred request is written into the command queue, fetched into the sequencer,
// and its first segment passes the output register onto res_o. While pop stays high,
// the sequencer emits one segment per cycle, and frames follow with no gap.
// A two-entry command queue sits between the decoder and the sequencer, so up to two
// requests are taken while a frame is being sent; full rises when it holds two.
// When the receiver stalls, the segment on res_o holds and the sequencer waits.
// Reset empties the queue and the output register; no clearing pass is needed.
// Depends on trce_pkg, trce_front, trce_cmd_fifo and trce_back.
module tristate_remote_code_encoder_unit import trce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output seg_t res_o
);

  cmd_t      front_cmd;
  logic      front_push;
  cmd_t      queue_cmd;
  cmd_ctrl_t queue_ctrl;
  logic      back_pop;

  trce_front u_front (
    .push_i     (push),
    .full_i     (full),
    .req_i      (req_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push)
  );

  trce_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .cmd_i  (front_cmd),
    .full_o (full),
    .ctrl_o (queue_ctrl),
    .pop_i  (back_pop),
    .cmd_o  (queue_cmd)
  );

  trce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (queue_ctrl),
    .cmd_i     (queue_cmd),
    .cmd_pop_o (back_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .seg_o     (res_o)
  );

endmodule

// ----- dv/trce_checker.sv -----
// Scoreboard for the tri-state code encoder: predicts the pulse segments of each accepted
// request and compares them with the segments that leave the block, in order.
// Depends on trce_pkg for the request, segment and symbol types and the duration constants.
module trce_checker import trce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  req_t        req_i,
  input  logic        empty,
  input  logic        pop,
  input  seg_t        res_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned segs_checked_o,
  output int unsigned frames_o,
  output int unsigned rejects_o
);

  // Group selectors that put an X into the four-symbol group; any other code gives 0000.
  localparam logic [1:0] GroupB = 2'd1;
  localparam logic [1:0] GroupC = 2'd2;

  seg_t        expected_segs[$];
  int unsigned fail_count    = 0;
  int unsigned segs_checked  = 0;
  int unsigned frame_count   = 0;
  int unsigned reject_count  = 0;
  int unsigned pending_count = 0;

  assign fail_count_o   = fail_count;
  assign pending_o      = pending_count;
  assign segs_checked_o = segs_checked;
  assign frames_o       = frame_count;
  assign rejects_o      = reject_count;

  function automatic sym_e group_symbol(logic [1:0] sel, int unsigned pos);
    sym_e s;
    s = SYM_ZERO;
    case (sel)
      GroupB: if (pos == 0) s = SYM_X;
      GroupC: if (pos == 1) s = SYM_X;
      default: s = SYM_ZERO;
    endcase
    return s;
  endfunction

  // Segment k of a symbol, in the order high, low, high, low.
  function automatic logic [5:0] pulse_len(sym_e s, int unsigned k);
    logic [3:0][5:0] lens;
    case (s)
      SYM_ONE: lens = {DurLong, DurShort, DurLong, DurShort};
      SYM_X:   lens = {DurShort, DurLong, DurLong, DurShort};
      default: lens = {DurShort, DurLong, DurShort, DurLong};
    endcase
    return lens[3 - k];
  endfunction

  task automatic encode_request(input req_t r);
    sym_e        word [WordSymbols];
    seg_t        s;
    int unsigned i;
    int unsigned k;
    if (r.house_code == CodeBad || r.unit_code == CodeBad) begin
      s.level          = 1'b0;
      s.duration_units = DurNone;
      s.last           = 1'b1;
      s.bad_code       = 1'b1;
      expected_segs.push_back(s);
      reject_count++;
      return;
    end
    for (i = 0; i < 4; i++) begin
      word[i]     = group_symbol(r.house_code, i);
      word[4 + i] = group_symbol(r.unit_code, i);
    end
    word[8]  = SYM_ZERO;
    word[9]  = SYM_X;
    word[10] = SYM_X;
    word[11] = r.switch_on ? SYM_X : SYM_ZERO;
    s.last     = 1'b0;
    s.bad_code = 1'b0;
    for (i = 0; i < WordSymbols; i++) begin
      for (k = 0; k < SegsPerSym; k++) begin
        s.level          = (k % 2 == 0);
        s.duration_units = pulse_len(word[i], k);
        expected_segs.push_back(s);
      end
    end
    // Sync pair closes the frame.
    s.level          = 1'b1;
    s.duration_units = DurShort;
    expected_segs.push_back(s);
    s.level          = 1'b0;
    s.duration_units = DurSync;
    s.last           = 1'b1;
    expected_segs.push_back(s);
    frame_count++;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] segment %0d: %s is %0d, expected %0d", $realtime, segs_checked, what,
             got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    seg_t want;
    if (rst_ni) begin
      if (push && !full) encode_request(req_i);
      if (pop && !empty) begin
        if (expected_segs.size() == 0) begin
          report_mismatch("segment with nothing outstanding, duration",
                          32'(res_o.duration_units), 0);
        end else begin
          want = expected_segs.pop_front();
          if (res_o.level !== want.level)
            report_mismatch("level", 32'(res_o.level), 32'(want.level));
          if (res_o.duration_units !== want.duration_units)
            report_mismatch("duration_units", 32'(res_o.duration_units),
                            32'(want.duration_units));
          if (res_o.last !== want.last)
            report_mismatch("last", 32'(res_o.last), 32'(want.last));
          if (res_o.bad_code !== want.bad_code)
            report_mismatch("bad_code", 32'(res_o.bad_code), 32'(want.bad_code));
        end
        segs_checked++;
      end
    end
    pending_count = expected_segs.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the tri-state code encoder: clock, reset, request stimulus with
// random gaps on both sides, and the verdict. Checking lives in trce_checker.
// Depends on trce_pkg, trce_checker and tristate_remote_code_encoder_unit.
module tb_top;
  import trce_pkg::*;

  localparam int unsigned RandomRequests = 100;
  localparam int unsigned CycleLimit     = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  req_t req_i  = '0;
  logic full;
  logic empty;
  seg_t res_o;

  logic        idle_en     = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned sent        = 0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned segs_checked;
  int unsigned frames;
  int unsigned rejects;

  always #5 clk_i = ~clk_i;

  tristate_remote_code_encoder_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .res_o (res_o)
  );

  trce_checker u_seg_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_i         (req_i),
    .empty         (empty),
    .pop           (pop),
    .res_o         (res_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .segs_checked_o(segs_checked),
    .frames_o      (frames),
    .rejects_o     (rejects)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d segments outstanding.", cycle_count,
               pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver side: stalls at random while idling is enabled.
  always @(negedge clk_i) begin
    pop <= rst_ni && !(idle_en && $urandom_range(0, 99) < 25);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input req_t r);
    while (idle_en && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_all_segments();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    req_t        r;
    int unsigned h;
    int unsigned u;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every supported house and unit pair, with the switch state alternating between pairs.
    for (h = 0; h < 3; h++) begin
      for (u = 0; u < 3; u++) begin
        r.house_code = 2'(h);
        r.unit_code  = 2'(u);
        r.switch_on  = 1'((h + u) % 2);
        send_request(r);
      end
    end
    // Unsupported codes on either field or both.
    r = '{house_code: CodeBad, unit_code: 2'd0, switch_on: 1'b0};
    send_request(r);
    r = '{house_code: 2'd0, unit_code: CodeBad, switch_on: 1'b1};
    send_request(r);
    r = '{house_code: CodeBad, unit_code: CodeBad, switch_on: 1'b1};
    send_request(r);
    r = '{house_code: CodeBad, unit_code: 2'd2, switch_on: 1'b0};
    send_request(r);
    r = '{house_code: 2'd1, unit_code: CodeBad, switch_on: 1'b0};
    send_request(r);
    wait_all_segments();

    for (n = 0; n < RandomRequests; n++) begin
      idle_en = !(n >= 40 && n < 70);
      if (n == 70) wait_all_segments();
      if ($urandom_range(0, 99) < 85) begin
        r.house_code = 2'($urandom_range(0, 2));
        r.unit_code  = 2'($urandom_range(0, 2));
      end else begin
        r.house_code = 2'($urandom_range(0, 3));
        r.unit_code  = 2'($urandom_range(0, 3));
      end
      r.switch_on = 1'($urandom_range(0, 1));
      send_request(r);
    end

    wait_all_segments();
    // Anything the block still sends now is unexpected and gets flagged.
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests: %0d full frames and %0d unsupported codes.", sent, frames,
             rejects);
    $display("Checked %0d segments in %0d cycles.", segs_checked, cycle_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
